// ===== rtl/dynamic_priority_scheduler_core_defines.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef DYNAMIC_PRIORITY_SCHEDULER_CORE_DEFINES_SVH
`define DYNAMIC_PRIORITY_SCHEDULER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dps_pkg.sv =====
// Package: types, codes and defaults of the dynamic priority scheduler.
`timescale 1ns / 1ps
package dps_pkg;

    localparam int MAX_TASKS_DEF = 16;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_RUN = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_ZERO  = 2'd3;

    typedef struct packed {
        logic [3:0]         id;
        logic signed [15:0] pri;
        logic [15:0]        rem;
        logic [15:0]        used;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_CMP,
        S_WB,
        S_HEAD_RD,
        S_HEAD,
        S_OUT
    } t_state;

endpackage

// ===== rtl/dynamic_priority_scheduler_core.sv =====
// Top level: dynamic priority scheduler with the task table in one memory.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-----------------------------------------
//  s       | in  | i_s_tvalid/o_s_tready  | tuser: command; tdata: task_id, prio, slices
//  m       | out | o_m_tvalid/i_m_tready  | tdata: status, id, prio, used, fin, left
//
// An add transaction has its result valid in the cycle after acceptance. For a run with two
// or more tasks, the exchange sort walks the table memory, one compare per cycle on its single
// read port; then the head is read, updated and written back to the tail of a circular table,
// or dropped from the table once it has finished.
// Ready returns in the cycle after the result transaction.
// Reset (synchronous, active low) empties the table; no clearing pass is needed.
// One transaction is in flight at a time; a stalled result holds the block.
`timescale 1ns / 1ps
`include "dynamic_priority_scheduler_core_defines.svh"
module dynamic_priority_scheduler_core
    import dps_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,  // task_id[3:0], start_priority[19:4], slices_needed[35:20]
    input  logic        i_s_tuser,  // command
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata   // status[1:0], ran_id[5:2], ran_priority[21:6],
                                    // ran_used[37:22], finished[38], tasks_left[43:39]
);

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [IW:0]   MAXI = (IW + 1)'(MAX_TASKS);
    localparam logic [CW-1:0] MAXC = CW'(MAX_TASKS);

    // Map a logical table position onto the circular memory.
    function automatic logic [IW-1:0] f_phys(input logic [IW-1:0] b, input logic [IW-1:0] l);
        logic [IW:0] s;
        s = {1'b0, b} + {1'b0, l};
        if (s >= MAXI) begin
            s = s - MAXI;
        end
        return s[IW-1:0];
    endfunction

    t_entry        mem [MAX_TASKS];
    t_entry        r_rdata;
    t_state        r_state, n_state;
    logic [IW-1:0] r_base, n_base;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_i, n_i;
    logic [IW-1:0] r_j, n_j;
    t_entry        r_cur, n_cur;
    logic [1:0]    r_status, n_status;
    logic [3:0]    r_rid, n_rid;
    logic [15:0]   r_rpri, n_rpri;
    logic [15:0]   r_rused, n_rused;
    logic          r_fin, n_fin;

    logic          rd_en;
    logic [IW-1:0] rd_lidx;
    logic          wr_en;
    logic [IW-1:0] wr_pidx;
    t_entry        wr_data;

    logic          s_acc;
    logic          in_cmd;
    logic [3:0]    in_id;
    logic [15:0]   in_pri;
    logic [15:0]   in_slices;
    logic          swap;
    logic          j_more;
    logic          i_more;
    t_entry        head;
    logic [IW-1:0] nb;
    logic [IW:0]   nb_sum;

    assign s_acc     = i_s_tvalid && o_s_tready;
    assign in_cmd    = i_s_tuser;
    assign in_id     = i_s_tdata[3:0];
    assign in_pri    = i_s_tdata[19:4];
    assign in_slices = i_s_tdata[35:20];

    assign swap   = r_cur.pri < r_rdata.pri;
    assign j_more = ({1'b0, CW'(r_j)} + 1'b1) < {1'b0, r_count};
    assign i_more = ({1'b0, CW'(r_i)} + 2'd2) < {1'b0, r_count};

    // Rotated base after the head leaves position zero.
    assign nb_sum = {1'b0, r_base} + 1'b1;
    assign nb     = (nb_sum >= MAXI) ? IW'(0) : nb_sum[IW-1:0];

    // Head after one slice: saturate priority low, used high; remaining drops.
    always_comb begin
        head = r_rdata;
        if (r_rdata.pri != 16'sh8000) begin
            head.pri = r_rdata.pri - 16'sd1;
        end
        if (r_rdata.rem != 16'd0) begin
            head.rem = r_rdata.rem - 16'd1;
        end
        if (r_rdata.used != 16'hFFFF) begin
            head.used = r_rdata.used + 16'd1;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    if (in_cmd == CMD_ADD || r_count == '0) begin
                        n_state = S_OUT;
                    end else if (r_count == CW'(1)) begin
                        n_state = S_HEAD_RD;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD:    n_state = S_CMP;
            S_CMP:     n_state = j_more ? S_CMP : S_WB;
            S_WB:      n_state = i_more ? S_LOAD : S_HEAD_RD;
            S_HEAD_RD: n_state = S_HEAD;
            S_HEAD:    n_state = S_OUT;
            S_OUT: begin
                if (i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Datapath, memory control and outputs.
    always_comb begin
        n_base   = r_base;
        n_count  = r_count;
        n_i      = r_i;
        n_j      = r_j;
        n_cur    = r_cur;
        n_status = r_status;
        n_rid    = r_rid;
        n_rpri   = r_rpri;
        n_rused  = r_rused;
        n_fin    = r_fin;
        rd_en    = 1'b0;
        rd_lidx  = '0;
        wr_en    = 1'b0;
        wr_pidx  = '0;
        wr_data  = r_cur;
        o_s_tready = (r_state == S_IDLE);
        o_m_tvalid = (r_state == S_OUT);
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_status = ST_OK;
                    n_rid    = '0;
                    n_rpri   = '0;
                    n_rused  = '0;
                    n_fin    = 1'b0;
                    if (in_cmd == CMD_ADD) begin
                        if (r_count >= MAXC) begin
                            n_status = ST_FULL;
                        end else if (in_slices == 16'd0) begin
                            n_status = ST_ZERO;
                        end else begin
                            wr_en   = 1'b1;
                            wr_pidx = f_phys(r_base, IW'(r_count));
                            wr_data = '{id: in_id, pri: in_pri, rem: in_slices, used: 16'd0};
                            n_count = r_count + CW'(1);
                        end
                    end else if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else if (r_count != CW'(1)) begin
                        rd_en   = 1'b1;
                        rd_lidx = '0;
                        n_i     = '0;
                    end
                end
            end
            S_LOAD: begin
                n_cur   = r_rdata;
                rd_en   = 1'b1;
                rd_lidx = r_i + IW'(1);
                n_j     = r_i + IW'(1);
            end
            S_CMP: begin
                // Swap by carrying the larger entry on and writing back the smaller.
                if (swap) begin
                    wr_en   = 1'b1;
                    wr_pidx = f_phys(r_base, r_j);
                    wr_data = r_cur;
                    n_cur   = r_rdata;
                end
                if (j_more) begin
                    rd_en   = 1'b1;
                    rd_lidx = r_j + IW'(1);
                    n_j     = r_j + IW'(1);
                end
            end
            S_WB: begin
                wr_en   = 1'b1;
                wr_pidx = f_phys(r_base, r_i);
                wr_data = r_cur;
                if (i_more) begin
                    n_i     = r_i + IW'(1);
                    rd_en   = 1'b1;
                    rd_lidx = r_i + IW'(1);
                end
            end
            S_HEAD_RD: begin
                rd_en   = 1'b1;
                rd_lidx = '0;
            end
            S_HEAD: begin
                n_base  = nb;
                n_rid   = head.id;
                n_rpri  = head.pri;
                n_rused = head.used;
                if (head.rem == 16'd0) begin
                    n_fin   = 1'b1;
                    n_count = r_count - CW'(1);
                end else begin
                    wr_en   = 1'b1;
                    wr_pidx = f_phys(nb, IW'(r_count - CW'(1)));
                    wr_data = head;
                end
            end
            default: begin
            end
        endcase
        o_m_tdata = {4'd0, 5'(r_count), r_fin, r_rused, r_rpri, r_rid, r_status};
    end

    // Task table memory: one write, one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_pidx] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[f_phys(r_base, rd_lidx)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_base  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_base  <= n_base;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_j      <= n_j;
        r_cur    <= n_cur;
        r_status <= n_status;
        r_rid    <= n_rid;
        r_rpri   <= n_rpri;
        r_rused  <= n_rused;
        r_fin    <= n_fin;
    end

    `DPS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= MAXC,
        "task count over capacity")
    `DPS_ASSERT_NOW(a_j_after_i, i_clk, i_rst_n, r_state == S_CMP, r_j > r_i,
        "sort index j not after i")
    `DPS_ASSERT_NEXT(a_busy_after_acc, i_clk, i_rst_n, s_acc, !o_s_tready,
        "ready right after a transaction")
    `DPS_ASSERT_NEXT(a_fin_drops, i_clk, i_rst_n,
        r_state == S_HEAD && head.rem == 16'd0,
        r_count == $past(r_count) - CW'(1), "finished task not removed")

endmodule
